[hdl/double_ended_queue_assert.svh]
// Assertion macros for the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[hdl/dq_pkg.sv]
package dq_pkg;

  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;
  localparam int TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic accept;
  } cmd_t;

endpackage

[hdl/dq_ctrl.sv]
module dq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output dq_pkg::cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_SHOW} state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new word may enter whenever the result slot is empty or draining.
  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_SHOW);
  assign cmd.accept = accept;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (accept) state_nxt = S_SHOW;
        else if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/dq_dpath.sv]
module dq_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::cmd_t                     cmd,
  input  logic        [dq_pkg::MODE_W-1:0] in_mode,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  input  logic        [dq_pkg::IDX_W-1:0]  in_index,
  output logic signed [dq_pkg::DATA_W-1:0] out_data,
  output logic        [dq_pkg::ST_W-1:0]   out_status,
  output logic        [dq_pkg::CNT_W-1:0]  out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > dq_pkg::IDX_W) ? CW : dq_pkg::IDX_W;
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] rd_data_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r;
  logic [dq_pkg::ST_W-1:0] st_r, st_nxt;
  logic use_r, use_nxt;

  logic          full, empty;
  logic [XW-1:0] idx_x, fill_x;
  logic [AW-1:0] head_dec, head_inc;
  logic [AW-1:0] wr_addr, rd_addr, rd_off;
  logic          wr_en;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) sum = sum - DEPTH_W;
    return sum[AW-1:0];
  endfunction

  always_comb begin
    full     = (fill_r == FULL_CNT);
    empty    = (fill_r == '0);
    idx_x    = XW'(in_index);
    fill_x   = XW'(fill_r);
    head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
    head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

    head_nxt = head_r;
    fill_nxt = fill_r;
    wr_en    = 1'b0;
    wr_addr  = wrap_add(head_r, AW'(fill_r));
    rd_off   = AW'(fill_r - 1'b1);
    use_nxt  = 1'b0;
    st_nxt   = dq_pkg::ST_OK;

    unique case (in_mode)
      dq_pkg::MODE_PUSH_TAIL: begin
        if (full) begin
          st_nxt = dq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      dq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          st_nxt = dq_pkg::ST_EMPTY;
        end else begin
          use_nxt  = 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      dq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          st_nxt = dq_pkg::ST_FULL;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = head_dec;
          head_nxt = head_dec;
          fill_nxt = fill_r + 1'b1;
        end
      end
      dq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          st_nxt = dq_pkg::ST_EMPTY;
        end else begin
          rd_off   = '0;
          use_nxt  = 1'b1;
          head_nxt = head_inc;
          fill_nxt = fill_r - 1'b1;
        end
      end
      dq_pkg::MODE_READ: begin
        if (idx_x >= fill_x) begin
          st_nxt = dq_pkg::ST_RANGE;
        end else begin
          rd_off  = AW'(idx_x);
          use_nxt = 1'b1;
        end
      end
      dq_pkg::MODE_CLEAR: begin
        head_nxt = '0;
        fill_nxt = '0;
      end
      default: ;
    endcase

    rd_addr = wrap_add(head_r, rd_off);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (cmd.accept) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Result fields of the word just taken; held until the next word enters.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_r  <= st_nxt;
      cnt_r <= fill_nxt;
      use_r <= use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[wr_addr] <= in_value;
    if (cmd.accept) rd_data_r <= mem[rd_addr];
  end

  assign out_data   = use_r ? rd_data_r : '0;
  assign out_status = st_r;
  assign out_count  = dq_pkg::CNT_W'(cnt_r);

endmodule

[hdl/double_ended_queue.sv]
// Double-ended queue over a circular buffer of DEPTH words.
// The result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle while out_tready is high; the result register, the head
// pointer and fill count update together; the buffer has one write and one read port.
// Reset (rst_n low, synchronous) empties the queue; buffer contents are kept.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dq_pkg::TDATA_W-1:0] in_tdata,   // value[31:0], index[37:32], zero[39:38]
  input  logic [dq_pkg::MODE_W-1:0]  in_tuser,   // mode[2:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dq_pkg::TDATA_W-1:0] out_tdata,  // data[31:0], count[38:32], zero[39]
  output logic [dq_pkg::ST_W-1:0]    out_tuser   // status[1:0]
);

  dq_pkg::cmd_t cmd;

  logic signed [dq_pkg::DATA_W-1:0] in_value;
  logic        [dq_pkg::IDX_W-1:0]  in_index;
  logic signed [dq_pkg::DATA_W-1:0] out_data;
  logic        [dq_pkg::CNT_W-1:0]  out_count;

  assign in_value = signed'(in_tdata[dq_pkg::DATA_W-1:0]);
  assign in_index = in_tdata[dq_pkg::DATA_W +: dq_pkg::IDX_W];

  assign out_tdata = {1'b0, out_count, out_data};

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_tuser),
    .in_value   (in_value),
    .in_index   (in_index),
    .out_data   (out_data),
    .out_status (out_tuser),
    .out_count  (out_count)
  );

endmodule

[hdl/dq_checker.sv]
`include "double_ended_queue_assert.svh"

module dq_checker #(
  parameter int DEPTH = 64
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [dq_pkg::MODE_W-1:0]  in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [dq_pkg::TDATA_W-1:0] out_tdata,
  input logic [dq_pkg::ST_W-1:0]    out_tuser
);

  localparam logic [dq_pkg::CNT_W-1:0] FULL_CNT = dq_pkg::CNT_W'(DEPTH);

  logic                       in_acc;
  logic [dq_pkg::CNT_W-1:0]   out_cnt;
  logic [dq_pkg::DATA_W-1:0]  out_dat;

  assign in_acc  = in_tvalid && in_tready;
  assign out_cnt = out_tdata[dq_pkg::DATA_W +: dq_pkg::CNT_W];
  assign out_dat = out_tdata[dq_pkg::DATA_W-1:0];

  // A stalled result holds.
  `DQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Every word taken yields a result on the next cycle.
  `DQ_ASSERT_NEXT(a_one_result, in_acc, out_tvalid)

  // An empty pop leaves an empty queue and answers zero.
  `DQ_ASSERT_SAME(a_empty_pop, out_tvalid && out_tuser == dq_pkg::ST_EMPTY,
    out_dat == '0 && out_cnt == '0)

  // A dropped push only happens at capacity.
  `DQ_ASSERT_SAME(a_full_push, out_tvalid && out_tuser == dq_pkg::ST_FULL,
    out_cnt == FULL_CNT && out_dat == '0)

  // Clear empties the queue.
  `DQ_ASSERT_NEXT(a_clear, in_acc && in_tuser == dq_pkg::MODE_CLEAR,
    out_cnt == '0 && out_tuser == dq_pkg::ST_OK)

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

[dv/tb_double_ended_queue.sv]
`timescale 1ns / 1ps

module tb_double_ended_queue;

  localparam int MODE_W  = dq_pkg::MODE_W;
  localparam int DATA_W  = dq_pkg::DATA_W;
  localparam int IDX_W   = dq_pkg::IDX_W;
  localparam int ST_W    = dq_pkg::ST_W;
  localparam int CNT_W   = dq_pkg::CNT_W;
  localparam int TDATA_W = dq_pkg::TDATA_W;

  localparam int QUEUE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;

  // Modes the block treats as no operation.
  localparam logic [MODE_W-1:0] MODE_NOP_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NOP_7 = 3'd7;

  // Bias of an operation mix in the random part.
  typedef enum int {MIX_PUSHY, MIX_POPPY, MIX_EVEN, MIX_READY} op_mix_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
  } dq_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic [MODE_W-1:0]    in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic [ST_W-1:0]      out_tuser;

  // Shadow copy of the queue.
  logic [DATA_W-1:0] shadow_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]  shadow_head;
  logic [CNT_W-1:0]  shadow_fill;

  dq_result_t pending_results[$];
  int         mismatches;
  int         burst_left;
  int         hold_reqs;
  int         hold_seen;
  int         hold_left;
  int         ready_style;
  int         ready_left;
  int         cycles;

  double_ended_queue #(.DEPTH(QUEUE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value[31:0], index[37:32], zero[39:38]
    .in_tuser   (in_tuser),   // mode[2:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // data[31:0], count[38:32], zero[39]
    .out_tuser  (out_tuser)   // status[1:0]
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int slot_of(int offset);
    return (int'(shadow_head) + offset) % QUEUE_DEPTH;
  endfunction

  // Apply one operation to the shadow queue and return the word it answers with.
  function automatic dq_result_t apply_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                                          logic [IDX_W-1:0] idx);
    dq_result_t r;
    r = '0;
    case (mode)
      dq_pkg::MODE_PUSH_TAIL: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          r.status = dq_pkg::ST_FULL;
        end else begin
          shadow_mem[slot_of(int'(shadow_fill))] = value;
          shadow_fill++;
        end
      end
      dq_pkg::MODE_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else begin
          shadow_fill--;
          r.data = shadow_mem[slot_of(int'(shadow_fill))];
        end
      end
      dq_pkg::MODE_PUSH_FRONT: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          r.status = dq_pkg::ST_FULL;
        end else begin
          shadow_head = (shadow_head == 0) ? IDX_W'(QUEUE_DEPTH - 1) : shadow_head - 1'b1;
          shadow_mem[shadow_head] = value;
          shadow_fill++;
        end
      end
      dq_pkg::MODE_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_mem[shadow_head];
          shadow_head = IDX_W'(slot_of(1));
          shadow_fill--;
        end
      end
      dq_pkg::MODE_READ: begin
        if (CNT_W'(idx) >= shadow_fill) begin
          r.status = dq_pkg::ST_RANGE;
        end else begin
          r.data = shadow_mem[slot_of(int'(idx))];
        end
      end
      dq_pkg::MODE_CLEAR: begin
        shadow_head = '0;
        shadow_fill = '0;
      end
      default: ;
    endcase
    r.count = shadow_fill;
    return r;
  endfunction

  // Offer one word; bursts of back-to-back words are separated by random gaps that may be zero.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, idx, value};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), apply_op(mode, value, idx));
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly hit stored words, sometimes anywhere in the index range.
  function automatic logic [IDX_W-1:0] pick_index();
    if (shadow_fill != 0 && $urandom_range(0, 3) != 0)
      return IDX_W'($urandom_range(0, int'(shadow_fill) - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [MODE_W-1:0] pick_push();
    return ($urandom_range(0, 1) != 0) ? dq_pkg::MODE_PUSH_TAIL : dq_pkg::MODE_PUSH_FRONT;
  endfunction

  function automatic logic [MODE_W-1:0] pick_pop();
    return ($urandom_range(0, 1) != 0) ? dq_pkg::MODE_POP_BACK : dq_pkg::MODE_POP_FRONT;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(op_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll == 0) return dq_pkg::MODE_CLEAR;
    if (roll == 1) return ($urandom_range(0, 1) != 0) ? MODE_NOP_6 : MODE_NOP_7;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_PUSHY: begin
        if (roll < 70) return pick_push();
        if (roll < 85) return pick_pop();
        return dq_pkg::MODE_READ;
      end
      MIX_POPPY: begin
        if (roll < 25) return pick_push();
        if (roll < 85) return pick_pop();
        return dq_pkg::MODE_READ;
      end
      MIX_READY: begin
        if (roll < 25) return pick_push();
        if (roll < 40) return pick_pop();
        return dq_pkg::MODE_READ;
      end
      default: begin
        if (roll < 40) return pick_push();
        if (roll < 80) return pick_pop();
        return dq_pkg::MODE_READ;
      end
    endcase
  endfunction

  task automatic send_random(op_mix_t mix);
    send_word(pick_mode(mix), pick_value(), pick_index());
  endtask

  task automatic test_directed();
    send_word(dq_pkg::MODE_CLEAR, '0, '0);
    send_word(dq_pkg::MODE_POP_BACK, '0, '0);
    send_word(dq_pkg::MODE_POP_FRONT, '0, '0);
    send_word(dq_pkg::MODE_READ, '0, 6'd0);
    send_word(dq_pkg::MODE_READ, '0, 6'd63);
    send_word(dq_pkg::MODE_PUSH_TAIL, 32'h7fff_ffff, 6'd63);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send_word(dq_pkg::MODE_PUSH_TAIL, 32'h0000_0000, 6'd0);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 6'd0);
    for (int i = 0; i < 5; i++) send_word(dq_pkg::MODE_READ, '0, IDX_W'(i));
    send_word(dq_pkg::MODE_READ, '0, 6'd63);
    send_word(MODE_NOP_6, 32'hffff_ffff, 6'd63);
    send_word(MODE_NOP_7, 32'h5555_aaaa, 6'd21);
    send_word(dq_pkg::MODE_POP_FRONT, '0, '0);
    send_word(dq_pkg::MODE_POP_BACK, '0, '0);
    send_word(dq_pkg::MODE_CLEAR, '0, '0);
    send_word(dq_pkg::MODE_POP_BACK, '0, '0);
    send_word(dq_pkg::MODE_PUSH_TAIL, $urandom, '0);
    send_word(dq_pkg::MODE_READ, '0, 6'd0);
    send_word(dq_pkg::MODE_POP_FRONT, '0, '0);
  endtask

  // Fill from both ends, overflow, read every index, then drain past empty.
  task automatic test_full_queue();
    send_word(dq_pkg::MODE_CLEAR, '0, '0);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_word(pick_push(), pick_value(), '0);
    send_word(dq_pkg::MODE_PUSH_TAIL, $urandom, '0);
    send_word(dq_pkg::MODE_PUSH_FRONT, $urandom, '0);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_word(dq_pkg::MODE_READ, '0, IDX_W'(i));
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) send_word(pick_pop(), '0, '0);
  endtask

  // Stall the result side for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_reqs++;
    for (int i = 0; i < 40; i++) send_random(MIX_PUSHY);
  endtask

  task automatic test_random();
    op_mix_t mix;
    for (int p = 0; p < 4; p++) begin
      case (p % 4)
        0:       mix = MIX_PUSHY;
        1:       mix = MIX_READY;
        2:       mix = MIX_POPPY;
        default: mix = MIX_EVEN;
      endcase
      for (int i = 0; i < 100; i++) send_random(mix);
    end
  endtask

  task automatic note_mismatch(string what, dq_result_t want, dq_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected data %h status %0d count %0d, got data %h status %0d count %0d",
               $realtime, what, want.data, want.status, want.count,
               got.data, got.status, got.count);
  endtask

  // Result checker.
  always @(posedge clk) begin
    dq_result_t got;
    dq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data   = out_tdata[DATA_W-1:0];
      got.count  = out_tdata[DATA_W+CNT_W-1:DATA_W];
      got.status = out_tuser;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Result-side stall pattern, with a long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (ready_left == 0) begin
          ready_style = $urandom_range(0, 2);
          ready_left  = $urandom_range(5, 60);
        end
        ready_left--;
        case (ready_style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("double_ended_queue test failed");
        $finish;
      end
    end
  end

  initial begin
    shadow_head = '0;
    shadow_fill = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_backpressure();
    test_random();
    test_backpressure();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule

[double_ended_queue.f]
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ctrl.sv
hdl/dq_dpath.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
dv/tb_double_ended_queue.sv
